FILE: rtl/core/adtsd_pkg.sv
package adtsd_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [3:0] SYNC_NIBBLE = 4'hF;
  localparam int unsigned HDR_BYTES  = 7;

  // Result status codes.
  localparam logic [1:0] ST_DATA      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN   = 2'd1;
  localparam logic [1:0] ST_SYNC_LOST = 2'd2;

  // Configuration register indexes.
  localparam logic REG_MAX_FRAME = 1'b0;
  localparam logic REG_RESYNC    = 1'b1;

  // Command kinds passed from the front part to the back part.
  localparam logic [1:0] CMD_BODY   = 2'd0;
  localparam logic [1:0] CMD_HEADER = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  typedef struct packed {
    logic [12:0] frame_len;
    logic        prot_present;
    logic [3:0]  rate;
    logic [2:0]  ch_raw;
  } hdr_fields_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      status;
    logic            last;
    logic [7:0]      data;
    logic [6:0][7:0] hdr;
    hdr_fields_t     fields;
  } cmd_t;

endpackage

FILE: rtl/core/adtsd_front.sv
module adtsd_front
  import adtsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        cmd_push,
  output cmd_t        cmd
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  logic [1:0]      phase_r, phase_nxt;
  logic [7:0]      prev_r, prev_nxt;
  logic [12:0]     bif_r, bif_nxt;
  logic [15:0]     hunt_r, hunt_nxt;
  hdr_fields_t     cur_r, cur_nxt;
  logic [12:0]     max_frame_r;
  logic [15:0]     resync_r;
  logic [5:0][7:0] hdr_r;

  logic [15:0] hunt_inc;
  logic [12:0] pos;
  logic [12:0] dec_len;
  logic        dec_no_crc;
  logic [12:0] dec_hs;
  logic        dec_bad;
  logic        hdr_wr;

  assign hunt_inc   = hunt_r + 16'd1;
  assign pos        = bif_r + 13'd1;
  assign dec_no_crc = hdr_r[1][0];
  assign dec_len    = {hdr_r[3][1:0], hdr_r[4], hdr_r[5][7:5]};
  assign dec_hs     = dec_no_crc ? 13'd7 : 13'd9;
  assign dec_bad    = (dec_len < dec_hs) || (dec_len > max_frame_r);

  always_comb begin
    phase_nxt  = phase_r;
    prev_nxt   = prev_r;
    bif_nxt    = bif_r;
    hunt_nxt   = hunt_r;
    cur_nxt    = cur_r;
    hdr_wr     = 1'b0;
    cmd_push   = 1'b0;
    cmd.kind   = CMD_BODY;
    cmd.status = ST_DATA;
    cmd.last   = 1'b0;
    cmd.data   = in_byte;
    cmd.hdr    = {in_byte, hdr_r[5], hdr_r[4], hdr_r[3], hdr_r[2], hdr_r[1], SYNC_BYTE};
    cmd.fields = cur_r;
    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (prev_r == SYNC_BYTE && in_byte[7:4] == SYNC_NIBBLE) begin
            hdr_wr    = 1'b1;
            bif_nxt   = 13'd2;
            hunt_nxt  = '0;
            phase_nxt = PH_HEAD;
          end else begin
            prev_nxt = in_byte;
            if (hunt_inc >= resync_r) begin
              hunt_nxt   = '0;
              cmd_push   = 1'b1;
              cmd.kind   = CMD_STATUS;
              cmd.status = ST_SYNC_LOST;
            end else begin
              hunt_nxt = hunt_inc;
            end
          end
        end
        PH_HEAD: begin
          bif_nxt = pos;
          if (bif_r[2:0] == 3'd6) begin
            cur_nxt.frame_len    = dec_len;
            cur_nxt.prot_present = ~dec_no_crc;
            cur_nxt.rate         = hdr_r[2][5:2];
            cur_nxt.ch_raw       = {hdr_r[2][0], hdr_r[3][7:6]};
            cmd.fields           = cur_nxt;
            cmd_push             = 1'b1;
            if (dec_bad) begin
              cmd.kind   = CMD_STATUS;
              cmd.status = ST_BAD_LEN;
              phase_nxt  = PH_HUNT;
              prev_nxt   = '0;
              bif_nxt    = '0;
            end else begin
              cmd.kind = CMD_HEADER;
              cmd.last = (dec_len == 13'd7);
              if (dec_len == 13'd7) begin
                phase_nxt = PH_HUNT;
                prev_nxt  = '0;
                bif_nxt   = '0;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end else begin
            hdr_wr = 1'b1;
          end
        end
        PH_BODY: begin
          bif_nxt  = pos;
          cmd_push = 1'b1;
          cmd.kind = CMD_BODY;
          cmd.last = (pos >= cur_r.frame_len);
          if (pos >= cur_r.frame_len) begin
            phase_nxt = PH_HUNT;
            prev_nxt  = '0;
            bif_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      prev_r      <= '0;
      bif_r       <= '0;
      hunt_r      <= '0;
      cur_r       <= '0;
      max_frame_r <= 13'd1536;
      resync_r    <= 16'd4096;
    end else begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      bif_r   <= bif_nxt;
      hunt_r  <= hunt_nxt;
      cur_r   <= cur_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MAX_FRAME: max_frame_r <= cfg_data[12:0];
          REG_RESYNC:    resync_r    <= cfg_data;
          default:       ;
        endcase
      end
    end
  end

  // In hunting the write lands the second sync byte at slot 1; slot 0 is
  // always the sync byte itself.
  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      if (phase_r == PH_HUNT) begin
        hdr_r[1] <= in_byte;
      end else begin
        hdr_r[bif_r[2:0]] <= in_byte;
      end
    end
  end

endmodule

FILE: rtl/core/adtsd_cmd_fifo.sv
module adtsd_cmd_fifo
  import adtsd_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic full,
  output logic empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

FILE: rtl/core/adtsd_back.sv
module adtsd_back
  import adtsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic        cmd_empty,
  output logic        cmd_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_first_of_frame,
  output logic        out_last_of_frame,
  output logic        out_last_of_burst,
  output logic [12:0] out_frame_bytes,
  output logic [3:0]  out_header_bytes,
  output logic [3:0]  out_rate_index,
  output logic [2:0]  out_channel_count
);

  logic        valid_r;
  logic [2:0]  idx_r, idx_nxt;
  logic        adv;
  logic        hdr_done;
  logic [7:0]  byte_nxt;
  logic [1:0]  status_nxt;
  logic        first_nxt, last_nxt, burst_nxt;

  logic [7:0]  byte_r;
  logic [1:0]  status_r;
  logic        first_r, last_r, burst_r;
  hdr_fields_t fields_r;

  // The output register takes a new result whenever it is empty or its
  // item is being popped in the same cycle.
  assign adv      = !valid_r || out_pop;
  assign hdr_done = (idx_r == 3'(HDR_BYTES - 1));

  always_comb begin
    idx_nxt    = idx_r;
    cmd_pop    = 1'b0;
    byte_nxt   = cmd.data;
    status_nxt = ST_DATA;
    first_nxt  = 1'b0;
    last_nxt   = 1'b0;
    burst_nxt  = 1'b1;
    unique case (cmd.kind)
      CMD_HEADER: begin
        byte_nxt  = cmd.hdr[idx_r];
        first_nxt = (idx_r == 3'd0);
        last_nxt  = hdr_done && cmd.last;
        burst_nxt = hdr_done;
      end
      CMD_STATUS: begin
        byte_nxt   = '0;
        status_nxt = cmd.status;
      end
      default: begin
        last_nxt = cmd.last;
      end
    endcase
    if (adv && !cmd_empty) begin
      if (cmd.kind == CMD_HEADER && !hdr_done) begin
        idx_nxt = idx_r + 3'd1;
      end else begin
        idx_nxt = '0;
        cmd_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (adv) begin
        valid_r <= !cmd_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !cmd_empty) begin
      byte_r   <= byte_nxt;
      status_r <= status_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      burst_r  <= burst_nxt;
      fields_r <= cmd.fields;
    end
  end

  assign out_empty          = !valid_r;
  assign out_byte           = byte_r;
  assign out_status         = status_r;
  assign out_first_of_frame = first_r;
  assign out_last_of_frame  = last_r;
  assign out_last_of_burst  = burst_r;
  assign out_frame_bytes    = fields_r.frame_len;
  assign out_header_bytes   = fields_r.prot_present ? 4'd9 : 4'd7;
  assign out_rate_index     = fields_r.rate;
  assign out_channel_count  = (fields_r.ch_raw == 3'd0) ? 3'd2 : fields_r.ch_raw;

endmodule

FILE: rtl/core/adts_frame_deframer.sv
// Channel   Handshake          Payload
// in        in_push / in_full  in_byte
// out       out_pop / out_empty  out_byte, out_status, frame flags, header fields
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while in_full is low; it goes through the command
// queue into the output register. A valid header becomes seven results,
// drained one per cycle by the back part while they are popped; later bytes
// queue up; in_full rises only when the CMD_DEPTH-entry command queue is full.
// Reset is synchronous; configuration registers return to 1536 and 4096.
module adts_frame_deframer
  import adtsd_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_first_of_frame,
  output logic        out_last_of_frame,
  output logic        out_last_of_burst,
  output logic [12:0] out_frame_bytes,
  output logic [3:0]  out_header_bytes,
  output logic [3:0]  out_rate_index,
  output logic [2:0]  out_channel_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t fr_cmd, q_cmd;
  logic fr_push, q_full, q_empty, q_pop;
  logic accept;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  adtsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (fr_push),
    .cmd       (fr_cmd)
  );

  adtsd_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (fr_push),
    .wr_cmd (fr_cmd),
    .pop    (q_pop),
    .rd_cmd (q_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  adtsd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (q_cmd),
    .cmd_empty          (q_empty),
    .cmd_pop            (q_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_byte           (out_byte),
    .out_status         (out_status),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_last_of_burst  (out_last_of_burst),
    .out_frame_bytes    (out_frame_bytes),
    .out_header_bytes   (out_header_bytes),
    .out_rate_index     (out_rate_index),
    .out_channel_count  (out_channel_count)
  );

endmodule
